>>> rtl/core/cmvn_pkg.sv
`timescale 1ns / 1ps
package cmvn_pkg;

  localparam int OP_W     = 2;
  localparam int COL_W    = 6;
  localparam int SAMPLE_W = 16;
  localparam int ROWS_W   = 11;
  localparam int SUM_W    = 27;
  localparam int SQ_W     = 41;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 1024;

  // wide datapath of the root search
  localparam int SRCH_W = 96;
  localparam int K_W    = 16;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCUM = 2'd1;
  localparam logic [OP_W-1:0] OP_NORM  = 2'd2;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_CALC
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_MUL1,
    N_MUL2,
    N_MUL3,
    N_INIT,
    N_ITER,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clr;
    logic [COL_W-1:0] col;
    logic [SUM_W-1:0] wr_sum;
    logic [SQ_W-1:0]  wr_sq;
  } stats_req_t;

endpackage

>>> rtl/core/cmvn_ifs.sv
`timescale 1ns / 1ps
interface cmvn_in_if;
  import cmvn_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [COL_W-1:0]           column;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output operation, output column, output sample, input ready);
  modport sink   (input valid, input operation, input column, input sample, output ready);
endinterface

interface cmvn_out_if;
  import cmvn_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] normalized;
  logic                       saturated;
  modport source (output valid, output normalized, output saturated, input ready);
  modport sink   (input valid, input normalized, input saturated, output ready);
endinterface

interface cmvn_cfg_if;
  import cmvn_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROWS_W-1:0] row_count;
  modport source (output valid, output row_count, input ready);
  modport sink   (input valid, input row_count, output ready);
endinterface

>>> rtl/core/cmvn_stats_mem.sv
`timescale 1ns / 1ps
module cmvn_stats_mem #(
  parameter int MAX_COLUMNS = cmvn_pkg::DEF_MAX_COLUMNS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cmvn_pkg::stats_req_t           req,
  output logic [cmvn_pkg::SUM_W-1:0]     rd_sum_r,
  output logic [cmvn_pkg::SQ_W-1:0]      rd_sq_r,
  output logic                           rd_valid_r
);
  import cmvn_pkg::*;

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [SUM_W-1:0]       sum_mem [MAX_COLUMNS];
  logic [SQ_W-1:0]        sq_mem  [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] valid_r;
  logic [AW-1:0]          addr;

  assign addr = AW'(req.col);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      sum_mem[addr] <= req.wr_sum;
      sq_mem[addr]  <= req.wr_sq;
    end
    if (req.rd_en) begin
      rd_sum_r <= sum_mem[addr];
      rd_sq_r  <= sq_mem[addr];
    end
  end

  // entries without a valid bit read with rd_valid_r low; the core treats them as zero statistics
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (req.rd_en) begin
      rd_valid_r <= valid_r[addr];
    end
  end

endmodule

>>> rtl/core/cmvn_norm_unit.sv
`timescale 1ns / 1ps
module cmvn_norm_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [cmvn_pkg::ROWS_W-1:0]          n,
  input  logic signed [cmvn_pkg::SAMPLE_W-1:0] s,
  input  logic signed [cmvn_pkg::SUM_W-1:0]    sum,
  input  logic [cmvn_pkg::SQ_W-1:0]            sq,
  output logic                                 done,
  output logic signed [cmvn_pkg::SAMPLE_W-1:0] normalized,
  output logic                                 saturated
);
  import cmvn_pkg::*;

  localparam int NQ_W = ROWS_W + SQ_W;
  localparam int SS_W = 2 * SUM_W;
  localparam int NS_W = ROWS_W + SAMPLE_W + 1;
  localparam int E_W  = SUM_W + 2;
  localparam int A_W  = E_W - 1;
  localparam int D_W  = NQ_W + 4;
  localparam int NN_W = 2 * ROWS_W;
  localparam logic [K_W-1:0] POS_MAX = {1'b0, {(K_W-1){1'b1}}};
  localparam logic [K_W-1:0] NEG_MAX = {1'b1, {(K_W-1){1'b0}}};

  norm_state_t st_r, st_nxt;

  logic [ROWS_W-1:0]          n_r;
  logic signed [SAMPLE_W-1:0] s_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]            sq_r;
  logic [NQ_W-1:0]            nq_r;
  logic [SS_W-1:0]            ss_r;
  logic signed [NS_W-1:0]     ns_r;
  logic signed [D_W-1:0]      d_r;
  logic [NN_W-1:0]            nn_r;
  logic [A_W-1:0]             a_r;
  logic [2*A_W-1:0]           a2_r;
  logic                       neg_r;
  logic signed [SRCH_W-1:0]   p_r, w_r, e_r, t_r;
  logic [3:0]                 j_r;
  logic [K_W-1:0]             k_r;

  logic signed [SS_W-1:0]   sum_x;
  logic signed [NS_W-1:0]   n_x, s_x;
  logic signed [E_W-1:0]    diff;
  logic signed [SRCH_W-1:0] p_try;

  assign sum_x = SS_W'(sum_r);
  assign n_x   = NS_W'(signed'({1'b0, n_r}));
  assign s_x   = NS_W'(s_r);
  assign diff  = E_W'(ns_r) - E_W'(sum_r);
  assign p_try = p_r + w_r + e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      N_IDLE: if (start) st_nxt = N_MUL1;
      N_MUL1: st_nxt = N_MUL2;
      N_MUL2: st_nxt = N_MUL3;
      N_MUL3: st_nxt = N_INIT;
      N_INIT: st_nxt = N_ITER;
      N_ITER: if (j_r == 4'd0) st_nxt = N_DONE;
      N_DONE: st_nxt = N_IDLE;
      default: st_nxt = N_IDLE;
    endcase
  end

  // k is built msb first; P = (2k-1)^2 D, W = (2k-1) D 2^(j+2), E = D 2^(2j+2)
  always_ff @(posedge clk) begin
    case (st_r)
      N_IDLE: begin
        n_r   <= n;
        s_r   <= s;
        sum_r <= sum;
        sq_r  <= sq;
      end
      N_MUL1: begin
        nq_r <= NQ_W'(n_r) * NQ_W'(sq_r);
        ss_r <= SS_W'(sum_x * sum_x);
        ns_r <= n_x * s_x;
      end
      N_MUL2: begin
        d_r   <= D_W'(nq_r) - D_W'(ss_r);
        nn_r  <= NN_W'(n_r) * NN_W'(n_r);
        neg_r <= diff < 0;
        a_r   <= (diff < 0) ? A_W'(-diff) : A_W'(diff);
      end
      N_MUL3: begin
        if (d_r < signed'(D_W'(nn_r))) d_r <= signed'(D_W'(nn_r));
        a2_r <= (2*A_W)'(a_r) * (2*A_W)'(a_r);
      end
      N_INIT: begin
        p_r <= SRCH_W'(d_r);
        w_r <= -(SRCH_W'(d_r) <<< 17);
        e_r <= SRCH_W'(d_r) <<< 32;
        t_r <= signed'(SRCH_W'(a2_r) << 18);
        j_r <= 4'd15;
        k_r <= '0;
      end
      N_ITER: begin
        if (p_try <= t_r) begin
          p_r      <= p_try;
          w_r      <= (w_r >>> 1) + e_r;
          k_r[j_r] <= 1'b1;
        end else begin
          w_r <= w_r >>> 1;
        end
        e_r <= e_r >>> 2;
        j_r <= j_r - 4'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    done       = (st_r == N_DONE);
    saturated  = 1'b0;
    normalized = signed'(k_r);
    if (neg_r) begin
      if (k_r > NEG_MAX) begin
        saturated  = 1'b1;
        normalized = signed'(NEG_MAX);
      end else begin
        normalized = signed'(K_W'(~k_r + 1'b1));
      end
    end else if (k_r > POS_MAX) begin
      saturated  = 1'b1;
      normalized = signed'(POS_MAX);
    end
  end

endmodule

>>> rtl/core/column_mean_variance_normalizer_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                   Handshake
// in_ch    in   operation[1:0] column[5:0] sample[15:0]   valid/ready
// out_ch   out  normalized[15:0] saturated                valid/ready
// cfg_ch   in   row_count[10:0]                           valid/ready
//
// Clear acts on acceptance. Accumulate: stats read, then write back.
// Normalize: accept, stats read, three multiply stages, init,
// the 16-step bit-serial root search and a done state.
// One item is in flight at a time. A result waiting in out_ch holds only
// a following normalize in its read cycle; clear and accumulate pass.
// rst_n (sync) sets row_count to 1 and clears all column valid bits.
module column_mean_variance_normalizer_core #(
  parameter int MAX_COLUMNS = cmvn_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = cmvn_pkg::DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  cmvn_in_if.sink    in_ch,
  cmvn_out_if.source out_ch,
  cmvn_cfg_if.sink   cfg_ch
);
  import cmvn_pkg::*;

  top_state_t st_r, st_nxt;

  logic [ROWS_W-1:0]          row_count_r;
  logic [OP_W-1:0]            op_r;
  logic [COL_W-1:0]           col_r;
  logic signed [SAMPLE_W-1:0] smp_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_norm_r;
  logic                       out_sat_r;

  stats_req_t       req;
  logic [SUM_W-1:0] rd_sum;
  logic [SQ_W-1:0]  rd_sq;
  logic             rd_valid;

  logic                       in_acc, col_in_range, have_stats, norm_start;
  logic [SUM_W-1:0]           old_sum;
  logic [SQ_W-1:0]            old_sq;
  logic [2*SAMPLE_W-1:0]      smp_sq;
  logic [ROWS_W-1:0]          n_eff;
  logic                       norm_done;
  logic signed [SAMPLE_W-1:0] norm_val;
  logic                       norm_sat;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign col_in_range = 32'(col_r) < MAX_COLUMNS;

  // row count: zero means one, clipped to MAX_ROWS
  always_comb begin
    n_eff = row_count_r;
    if (row_count_r == '0) begin
      n_eff = ROWS_W'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      n_eff = ROWS_W'(MAX_ROWS);
    end
  end

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROWS_W'(1);
    end else if (cfg_ch.valid) begin
      row_count_r <= cfg_ch.row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_ch.operation;
      col_r <= in_ch.column;
      smp_r <= in_ch.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign have_stats = col_in_range && rd_valid;
  assign old_sum    = have_stats ? rd_sum : '0;
  assign old_sq     = have_stats ? rd_sq : '0;
  assign smp_sq     = unsigned'(32'(smp_r) * 32'(smp_r));

  always_comb begin
    st_nxt      = st_r;
    req         = '0;
    req.col     = in_ch.column;
    norm_start  = 1'b0;
    in_ch.ready = (st_r == T_IDLE);
    unique case (st_r)
      T_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.operation)
            OP_CLEAR: req.clr = 1'b1;
            OP_ACCUM, OP_NORM: begin
              req.rd_en = 1'b1;
              st_nxt    = T_READ;
            end
            default: ;
          endcase
        end
      end
      T_READ: begin
        req.col = col_r;
        if (op_r == OP_ACCUM) begin
          // read-modify-write; sums wrap at their widths
          req.wr_en  = col_in_range;
          req.wr_sum = old_sum + SUM_W'(smp_r);
          req.wr_sq  = old_sq + SQ_W'(smp_sq);
          st_nxt     = T_IDLE;
        end else if (!out_valid_r) begin
          // read data holds here until the result register is free
          norm_start = 1'b1;
          st_nxt     = T_CALC;
        end
      end
      T_CALC: if (norm_done) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  cmvn_stats_mem #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .rd_sum_r   (rd_sum),
    .rd_sq_r    (rd_sq),
    .rd_valid_r (rd_valid)
  );

  cmvn_norm_unit u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (norm_start),
    .n          (n_eff),
    .s          (smp_r),
    .sum        (signed'(old_sum)),
    .sq         (old_sq),
    .done       (norm_done),
    .normalized (norm_val),
    .saturated  (norm_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (norm_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (norm_done) begin
      out_norm_r <= norm_val;
      out_sat_r  <= norm_sat;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.normalized = out_norm_r;
  assign out_ch.saturated  = out_sat_r;

  // a finished result never lands on a waiting one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> !out_valid_r)
    else $error("result overwritten while waiting");

  // the root search only finishes for a normalize in flight
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (st_r == T_CALC))
    else $error("norm unit done outside calc");

  // accumulate and normalize read the stats before anything else
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.operation == OP_ACCUM || in_ch.operation == OP_NORM))
      |=> (st_r == T_READ))
    else $error("stats read skipped");

endmodule
